[hdl/rba_pkg.sv]
// Shared types and constants for the region bump allocator.
`timescale 1ns / 1ps

package rba_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W       = IDX_W + 1;
  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = ADDR_W + 1;
  localparam int WORD_ROUND  = 3;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_FULL    = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  // One region descriptor as read back from the table.
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] limit;
    logic [ADDR_W-1:0] top;
  } rba_entry_t;

  // Table write request: a full descriptor on add, the top alone otherwise.
  typedef struct packed {
    logic              full_we;
    logic              top_we;
    logic [IDX_W-1:0]  addr;
    rba_entry_t        entry;
  } rba_wr_t;

endpackage

[hdl/rba_table.sv]
// Region descriptor table: one write port, one registered read port.
`timescale 1ns / 1ps

module rba_table (
  input  logic                      clk,
  input  rba_pkg::rba_wr_t          wr,
  input  logic [rba_pkg::IDX_W-1:0] rd_addr,
  output rba_pkg::rba_entry_t       rd_data
);

  logic [rba_pkg::ADDR_W-1:0] start_mem [rba_pkg::MAX_REGIONS];
  logic [rba_pkg::ADDR_W-1:0] limit_mem [rba_pkg::MAX_REGIONS];
  logic [rba_pkg::ADDR_W-1:0] top_mem   [rba_pkg::MAX_REGIONS];

  always_ff @(posedge clk) begin
    if (wr.full_we) begin
      start_mem[wr.addr] <= wr.entry.start;
      limit_mem[wr.addr] <= wr.entry.limit;
    end
    if (wr.full_we || wr.top_we) begin
      top_mem[wr.addr] <= wr.entry.top;
    end
    rd_data.start <= start_mem[rd_addr];
    rd_data.limit <= limit_mem[rd_addr];
    rd_data.top   <= top_mem[rd_addr];
  end

endmodule

[hdl/region_bump_allocator.sv]
// Top level of the multi-region bump allocator: request sequencer and result register.
`timescale 1ns / 1ps

// Channel  Direction  tdata (low bit up)                                  tuser
// in_      slave      region_begin, region_end, request_size,             op [1:0]
//                     free_address (128 bits)
// out_     master     alloc_address (32 bits)                             status [1:0]
//
// One request is taken at a time; in_tready is high only while the sequencer
// is idle. An add passes through the dispatch state and the push state to a
// valid result. An allocate or free also visits up to MAX_REGIONS regions;
// each visit is one table read followed by one pass through the shared
// subtract-and-compare unit. A result stalled on out_tready holds the sequencer
// until the output register frees. Reset (rst_n low, synchronous) empties the
// table count and the cursor; table contents are left as they are and are never
// read before being written.

module region_bump_allocator (
  input  logic         clk,
  input  logic         rst_n,
  // Input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [31:0] region_begin, [63:32] region_end,
                                   // [95:64] request_size, [127:96] free_address
  input  logic [1:0]   in_tuser,   // [1:0] op
  // Result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // [31:0] alloc_address
  output logic [1:0]   out_tuser   // [1:0] status
);

  localparam int AW = rba_pkg::ADDR_W;
  localparam int SW = rba_pkg::SIZE_W;
  localparam int IW = rba_pkg::IDX_W;
  localparam int CW = rba_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_CHECK,
    S_PUSH
  } state_t;

  state_t           state_r;
  rba_pkg::op_t     op_r;
  logic [AW-1:0]    begin_r;
  logic [AW-1:0]    end_r;
  logic [SW-1:0]    need_r;      // size rounded up to a word, kept at 33 bits
  logic [AW-1:0]    faddr_r;
  logic [CW-1:0]    count_r;
  logic [IW-1:0]    cursor_r;
  logic [IW-1:0]    idx_r;
  logic [AW-1:0]    res_addr_r;
  rba_pkg::status_t res_status_r;
  logic             out_valid_r;
  logic [AW-1:0]    out_addr_r;
  rba_pkg::status_t out_status_r;

  rba_pkg::rba_wr_t    wr;
  rba_pkg::rba_entry_t rd;

  logic [SW-1:0] size_in;
  logic [SW-1:0] size_round;
  logic [AW-1:0] sub_a;
  logic [AW-1:0] sub_b;
  logic [SW-1:0] diff;
  logic          borrow;
  logic          alloc_fit;
  logic          free_hit;
  logic          free_exact;
  logic [CW-1:0] idx_ext;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] count_dec;
  logic          in_acc;
  logic          out_free;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  assign size_in    = {1'b0, in_tdata[95:64]};
  assign size_round = (size_in + SW'(rba_pkg::WORD_ROUND)) & ~SW'(rba_pkg::WORD_ROUND);

  // Shared subtract unit: room left (limit - top) on allocate, used bytes
  // above the pointer (top - address) on free.
  always_comb begin
    if (op_r == rba_pkg::OP_ALLOC) begin
      sub_a = rd.limit;
      sub_b = rd.top;
    end else begin
      sub_a = rd.top;
      sub_b = faddr_r;
    end
  end

  assign diff       = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow     = diff[AW];
  assign alloc_fit  = !borrow && (diff >= need_r);
  // Pointer lies in [start, top): no borrow and a nonzero gap below top.
  assign free_hit   = (faddr_r >= rd.start) && !borrow && (diff[AW-1:0] != '0);
  assign free_exact = (diff == need_r);

  assign idx_ext   = {1'b0, idx_r};
  assign idx_inc   = idx_ext + CW'(1);
  assign count_dec = count_r - CW'(1);

  // Table write port, driven only from the decision cycles.
  always_comb begin
    wr          = '0;
    wr.addr     = idx_r;
    wr.entry    = rd;
    if (state_r == S_DISPATCH && op_r == rba_pkg::OP_ADD &&
        count_r < CW'(rba_pkg::MAX_REGIONS)) begin
      wr.full_we     = 1'b1;
      wr.addr        = count_r[IW-1:0];
      wr.entry.start = begin_r;
      wr.entry.limit = end_r;
      wr.entry.top   = begin_r;
    end else if (state_r == S_CHECK) begin
      if (op_r == rba_pkg::OP_ALLOC && alloc_fit) begin
        wr.top_we    = 1'b1;
        wr.entry.top = rd.top + need_r[AW-1:0];
      end else if (op_r == rba_pkg::OP_FREE && free_hit && free_exact) begin
        wr.top_we    = 1'b1;
        wr.entry.top = faddr_r;
      end
    end
  end

  rba_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (idx_r),
    .rd_data (rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one is loaded this cycle.
      if (out_valid_r && out_tready && state_r != S_PUSH) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r    <= rba_pkg::op_t'(in_tuser);
            begin_r <= in_tdata[31:0];
            end_r   <= in_tdata[63:32];
            need_r  <= size_round;
            faddr_r <= in_tdata[127:96];
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_addr_r <= '0;
          case (op_r)
            rba_pkg::OP_ADD: begin
              state_r <= S_PUSH;
              if (count_r < CW'(rba_pkg::MAX_REGIONS)) begin
                count_r      <= count_r + CW'(1);
                res_status_r <= rba_pkg::ST_OK;
              end else begin
                res_status_r <= rba_pkg::ST_FULL;
              end
            end
            rba_pkg::OP_ALLOC: begin
              if ({1'b0, cursor_r} >= count_r) begin
                res_status_r <= rba_pkg::ST_NO_FIT;
                state_r      <= S_PUSH;
              end else begin
                idx_r   <= cursor_r;
                state_r <= S_READ;
              end
            end
            rba_pkg::OP_FREE: begin
              if (count_r == '0) begin
                res_status_r <= rba_pkg::ST_IGNORED;
                state_r      <= S_PUSH;
              end else begin
                // Clamp the walk start to the last region present.
                if ({1'b0, cursor_r} >= count_r) begin
                  idx_r <= count_dec[IW-1:0];
                end else begin
                  idx_r <= cursor_r;
                end
                state_r <= S_READ;
              end
            end
            default: begin
              // Unused op: no change, zero address, ok.
              res_status_r <= rba_pkg::ST_OK;
              state_r      <= S_PUSH;
            end
          endcase
        end
        S_READ: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (op_r == rba_pkg::OP_ALLOC) begin
            if (alloc_fit) begin
              cursor_r     <= idx_r;
              res_addr_r   <= rd.top;
              res_status_r <= rba_pkg::ST_OK;
              state_r      <= S_PUSH;
            end else if (idx_inc >= count_r) begin
              res_status_r <= rba_pkg::ST_NO_FIT;
              state_r      <= S_PUSH;
            end else begin
              idx_r   <= idx_inc[IW-1:0];
              state_r <= S_READ;
            end
          end else begin
            if (free_hit) begin
              if (free_exact) begin
                cursor_r     <= idx_r;
                res_status_r <= rba_pkg::ST_OK;
              end else begin
                res_status_r <= rba_pkg::ST_IGNORED;
              end
              state_r <= S_PUSH;
            end else if (idx_r == '0) begin
              res_status_r <= rba_pkg::ST_IGNORED;
              state_r      <= S_PUSH;
            end else begin
              idx_r   <= idx_r - IW'(1);
              state_r <= S_READ;
            end
          end
        end
        S_PUSH: begin
          // Hold here until the output register can take the result.
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_addr_r   <= res_addr_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_status_r;

endmodule
